### hdl/aisa_pkg.sv
package aisa_pkg;

    localparam int ADC_BITS = 12;
    localparam int OUT_RES = 1024;
    localparam int RES_W = 10;
    localparam int CAL_W = 16;
    localparam int OFS_W = 10;
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 1;

    localparam int AVG_SAMPLES_DEF = 8;
    localparam int NUM_CHANNELS_DEF = 2;

    localparam int PROD_W = $clog2(((2 ** ADC_BITS) - 1) * OUT_RES + 1);

    localparam logic [CFG_IDX_W-1:0] REG_CAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 1'b1;

    localparam logic [CAL_W-1:0] CAL_RESET = CAL_W'(4095);
    localparam logic [RES_W-1:0] SAT_VALUE = RES_W'(OUT_RES - 1);

    typedef struct packed {
        logic clear;
        logic accept;
        logic commit;
        logic load_out;
    } aisa_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic div_done;
        logic out_free;
    } aisa_stat_t;

endpackage

### hdl/analog_input_scale_average_top.sv
// Scales raw converter samples of up to NUM_CHANNELS inputs and smooths each
// channel with a moving average over AVG_SAMPLES stored values.
// Input channel: s_valid/s_ready carry one item (s_channel, s_raw_sample).
// Result channel: m_valid/m_ready carry one item per input item
// (m_result_channel, m_filtered_value, m_saturated).
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 calibration divisor, 1 zero offset); write only while the block is idle.
// A restoring divider, one quotient bit per cycle over D = 22 bits
// (raw * resolution width), sets the rate; the average is a constant
// reciprocal multiply. An accepted item is scaled by the divider, stored in
// its channel's ring unless saturated, and then loaded into the output
// register, saturated or not; the next item is accepted only after that load.
// After reset the block clears all 2 ** (ch bits + pointer bits) entries of
// the sample rings (16 by default), one entry per cycle, before s_ready rises.
// A stalled receiver holds the result in the output register; the next item
// is still accepted and processed, and waits only to be loaded.
module analog_input_scale_average_top #(
    parameter int AVG_SAMPLES = aisa_pkg::AVG_SAMPLES_DEF,
    parameter int NUM_CHANNELS = aisa_pkg::NUM_CHANNELS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [aisa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [aisa_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_channel,
    input  logic [aisa_pkg::ADC_BITS-1:0]  s_raw_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_result_channel,
    output logic [aisa_pkg::RES_W-1:0]     m_filtered_value,
    output logic                           m_saturated
);

    import aisa_pkg::*;

    aisa_cmd_t  cmd;
    aisa_stat_t stat;

    aisa_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    aisa_datapath #(
        .AVG_SAMPLES (AVG_SAMPLES),
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_channel       (s_channel),
        .s_raw_sample    (s_raw_sample),
        .m_ready         (m_ready),
        .cmd             (cmd),
        .stat            (stat),
        .m_valid         (m_valid),
        .m_result_channel(m_result_channel),
        .m_filtered_value(m_filtered_value),
        .m_saturated     (m_saturated)
    );

endmodule

### hdl/aisa_ram.sv
module aisa_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/aisa_div.sv
module aisa_div #(
    parameter int N_W = 22,
    parameter int D_W = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [N_W-1:0] quotient
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [D_W-1:0]   rem_reg;
    logic [N_W-1:0]   quo_reg;
    logic [D_W-1:0]   div_reg;

    logic [D_W:0] trial;
    logic [D_W:0] diff;
    logic         ge;

    assign trial = {rem_reg, quo_reg[N_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign ge    = trial >= {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(N_W);
                rem_reg  <= '0;
                quo_reg  <= dividend;
                div_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
                quo_reg <= {quo_reg[N_W-2:0], ge};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### hdl/aisa_datapath.sv
module aisa_datapath #(
    parameter int AVG_SAMPLES = aisa_pkg::AVG_SAMPLES_DEF,
    parameter int NUM_CHANNELS = aisa_pkg::NUM_CHANNELS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [aisa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [aisa_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           s_channel,
    input  logic [aisa_pkg::ADC_BITS-1:0]  s_raw_sample,
    input  logic                           m_ready,
    input  aisa_pkg::aisa_cmd_t            cmd,
    output aisa_pkg::aisa_stat_t           stat,
    output logic                           m_valid,
    output logic                           m_result_channel,
    output logic [aisa_pkg::RES_W-1:0]     m_filtered_value,
    output logic                           m_saturated
);

    import aisa_pkg::*;

    localparam int PTR_W = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;
    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int RAM_AW = CH_W + PTR_W;
    localparam int RAM_DEPTH = 2 ** RAM_AW;
    localparam int SUM_W = $clog2(AVG_SAMPLES * (OUT_RES - 1) + 1);
    localparam int DIV_W = (PROD_W > SUM_W) ? PROD_W : SUM_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(AVG_SAMPLES - 1);
    localparam int AVG_SH = SUM_W + PTR_W;
    localparam int AVG_MUL = (2 ** AVG_SH + AVG_SAMPLES - 1) / AVG_SAMPLES;
    localparam int MUL_W = $clog2(AVG_MUL + 1);
    localparam int AVG_PW = SUM_W + MUL_W;

    logic [CAL_W-1:0]  cal_reg;
    logic [OFS_W-1:0]  ofs_reg;
    logic              chan_reg;
    logic [CH_W-1:0]   ch_reg;
    logic [PTR_W-1:0]  ptr_reg [NUM_CHANNELS];
    logic [SUM_W-1:0]  sum_reg [NUM_CHANNELS];
    logic              sat_reg;
    logic [RAM_AW-1:0] clr_cnt_reg;
    logic              m_valid_reg;
    logic              m_chan_reg;
    logic [RES_W-1:0]  m_val_reg;
    logic              m_sat_reg;

    logic [CH_W-1:0]   ch_idx;
    logic [PTR_W-1:0]  cur_ptr;
    logic [RAM_AW-1:0] rd_addr;
    logic [RES_W-1:0]  old_sample;
    logic [DIV_W-1:0]  quo;
    logic [DIV_W:0]    scaled_ext;
    logic              sat;
    logic [RES_W-1:0]  scaled;
    logic              commit_ok;
    logic [SUM_W-1:0]  sum_new;
    logic [AVG_PW-1:0] avg_prod;
    logic [RES_W-1:0]  avg;
    logic [PROD_W-1:0] prod;
    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic [CAL_W-1:0]  div_divisor;
    logic              div_done;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [RES_W-1:0]  ram_wdata;

    assign ch_idx  = (NUM_CHANNELS > 1) ? CH_W'(s_channel) : '0;
    assign cur_ptr = ptr_reg[ch_reg];
    assign rd_addr = {ch_reg, cur_ptr};

    assign scaled_ext = (quo != '0) ? ({1'b0, quo} + (DIV_W + 1)'(ofs_reg)) : {1'b0, quo};
    assign sat        = scaled_ext >= (DIV_W + 1)'(OUT_RES);
    assign scaled     = scaled_ext[RES_W-1:0];
    assign commit_ok  = cmd.commit & ~sat;
    assign sum_new    = sum_reg[ch_reg] - SUM_W'(old_sample) + SUM_W'(scaled);

    // floor(sum / AVG_SAMPLES) by reciprocal multiply, exact over the sum range
    assign avg_prod = AVG_PW'(sum_reg[ch_reg]) * AVG_PW'(AVG_MUL);
    assign avg      = avg_prod[AVG_SH +: RES_W];

    assign prod         = PROD_W'(s_raw_sample * OUT_RES);
    assign div_start    = cmd.accept;
    assign div_dividend = DIV_W'(prod);
    assign div_divisor  = cal_reg;

    assign ram_we    = cmd.clear | commit_ok;
    assign ram_waddr = cmd.clear ? clr_cnt_reg : rd_addr;
    assign ram_wdata = cmd.clear ? '0 : scaled;

    aisa_div #(
        .N_W(DIV_W),
        .D_W(CAL_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(div_dividend),
        .divisor (div_divisor),
        .done    (div_done),
        .quotient(quo)
    );

    aisa_ram #(
        .WIDTH(RES_W),
        .DEPTH(RAM_DEPTH)
    ) u_ring (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(rd_addr),
        .rdata(old_sample)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg     <= CAL_RESET;
            ofs_reg     <= '0;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                ptr_reg[i] <= '0;
                sum_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_CAL: begin
                        cal_reg <= cfg_data[CAL_W-1:0];
                    end
                    REG_OFFSET: begin
                        ofs_reg <= cfg_data[OFS_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.clear) begin
                clr_cnt_reg <= clr_cnt_reg + RAM_AW'(1);
            end
            if (cmd.accept) begin
                chan_reg <= s_channel;
                ch_reg   <= ch_idx;
            end
            if (cmd.commit) begin
                sat_reg <= sat;
            end
            if (commit_ok) begin
                ptr_reg[ch_reg] <= (cur_ptr == PTR_LAST) ? '0 : cur_ptr + PTR_W'(1);
                sum_reg[ch_reg] <= sum_new;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
                m_chan_reg  <= chan_reg;
                m_val_reg   <= sat_reg ? SAT_VALUE : avg;
                m_sat_reg   <= sat_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.clear_last = clr_cnt_reg == '1;
    assign stat.div_done   = div_done;
    assign stat.out_free   = ~m_valid_reg | m_ready;

    assign m_valid          = m_valid_reg;
    assign m_result_channel = m_chan_reg;
    assign m_filtered_value = m_val_reg;
    assign m_saturated      = m_sat_reg;

endmodule

### hdl/aisa_ctrl.sv
module aisa_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  aisa_pkg::aisa_stat_t stat,
    output aisa_pkg::aisa_cmd_t  cmd
);

    import aisa_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCALE,
        ST_EMIT
    } state_t;

    state_t state_reg;

    assign s_ready      = state_reg == ST_IDLE;
    assign cmd.clear    = state_reg == ST_CLEAR;
    assign cmd.accept   = (state_reg == ST_IDLE) & s_valid;
    assign cmd.commit   = (state_reg == ST_SCALE) & stat.div_done;
    assign cmd.load_out = (state_reg == ST_EMIT) & stat.out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    if (stat.clear_last) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE: begin
                    if (stat.div_done) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (stat.out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
